/* rtl/sorted_priority_queue_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion that is switched off while reset is asserted.
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sorted priority queue assertion failed");

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("sorted priority queue assertion failed");

`else

`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Store size and stored priority width.
  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 8;

  // Fixed port field widths.
  localparam int PRIO_W    = 8;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // Entry count holds 0 to CAPACITY inclusive.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Request kinds.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the incoming request fields
    logic push;       // insert the captured entry
    logic pop;        // remove the front entry
    logic err_empty;  // report a dequeue from an empty queue
    logic err_full;   // report a dropped enqueue
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } spq_sts_t;

endpackage

`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller state machine of the sorted priority queue.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module spq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              req_type_i,
  input  wire spq_pkg::spq_sts_t sts_i,
  output spq_pkg::spq_cmd_t      cmd_o,
  output logic                   done_o
);
  import spq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       req_type_q;
  logic       accept;

  // A request is taken whenever the datapath is not executing one.
  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;
  assign done_o = (state_q == ST_RESP);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and captured request kind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_type_q <= REQ_ENQ;
    end else begin
      state_q <= state_d;
      if (accept) req_type_q <= req_type_i;
    end
  end

  // Decide the operation from the request kind and the fill state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    if (state_q == ST_EXEC) begin
      if (req_type_q == REQ_ENQ) begin
        cmd_o.push     = !sts_i.full;
        cmd_o.err_full = sts_i.full;
      end else begin
        cmd_o.pop       = !sts_i.empty;
        cmd_o.err_empty = sts_i.empty;
      end
    end
  end

  `SPQ_ASSERT(a_done_follows_exec, done_o |-> $past(busy))
  `SPQ_ASSERT(a_accept_to_result, accept |=> busy ##1 done_o)
  `SPQ_ASSERT(a_one_operation, $onehot0({cmd_o.push, cmd_o.pop, cmd_o.err_empty, cmd_o.err_full}))
  `SPQ_ASSERT(a_exec_has_operation,
    busy |-> (cmd_o.push || cmd_o.pop || cmd_o.err_empty || cmd_o.err_full))

endmodule

`default_nettype wire

/* rtl/spq_datapath.sv */
// Datapath of the sorted priority queue: a chain of sorted entry cells.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module spq_datapath (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic [spq_pkg::PRIO_W-1:0]              prio_i,
  input  wire logic signed [spq_pkg::PAYLOAD_W-1:0]    payload_i,
  input  wire spq_pkg::spq_cmd_t                       cmd_i,
  output spq_pkg::spq_sts_t                            sts_o,
  output logic [spq_pkg::STATUS_W-1:0]                 status_o,
  output logic signed [spq_pkg::PAYLOAD_W-1:0]         out_payload_o,
  output logic [spq_pkg::PRIO_W-1:0]                   out_prio_o,
  output logic [spq_pkg::OCC_W-1:0]                    occupancy_o
);
  import spq_pkg::*;

  // Entry cells; slot 0 is the front.
  logic [PRIO_BITS-1:0] prio_q [CAPACITY];
  logic [PAYLOAD_W-1:0] pay_q  [CAPACITY];
  logic [PRIO_BITS-1:0] prio_d [CAPACITY];
  logic [PAYLOAD_W-1:0] pay_d  [CAPACITY];
  logic [CAPACITY-1:0]  keep;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [PRIO_BITS-1:0] req_prio_q;
  logic [PAYLOAD_W-1:0] req_pay_q;

  logic [STATUS_W-1:0]  status_q;
  logic [PAYLOAD_W-1:0] res_pay_q;
  logic [PRIO_BITS-1:0] res_prio_q;

  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CNT_W'(CAPACITY));

  // Capture the request fields when the beat is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_prio_q <= PRIO_BITS'(prio_i);
      req_pay_q  <= payload_i;
    end
  end

  // Every occupied cell whose priority is lower or equal stays in place.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CNT_W'(i) < count_q) && (prio_q[i] <= req_prio_q);
    end
  end

  // Per-cell next value: keep, take the new entry, or shift by one slot.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                 prev_keep;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;
    logic [PAYLOAD_W-1:0] prev_pay, next_pay;

    if (g == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_prio = prio_q[g];
      assign prev_pay  = pay_q[g];
    end else begin : g_inner
      assign prev_keep = keep[g-1];
      assign prev_prio = prio_q[g-1];
      assign prev_pay  = pay_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_prio = prio_q[g];
      assign next_pay  = pay_q[g];
    end else begin : g_notlast
      assign next_prio = prio_q[g+1];
      assign next_pay  = pay_q[g+1];
    end

    always_comb begin
      prio_d[g] = prio_q[g];
      pay_d[g]  = pay_q[g];
      if (cmd_i.push && !keep[g]) begin
        if (prev_keep) begin
          prio_d[g] = req_prio_q;
          pay_d[g]  = req_pay_q;
        end else begin
          prio_d[g] = prev_prio;
          pay_d[g]  = prev_pay;
        end
      end else if (cmd_i.pop) begin
        prio_d[g] = next_prio;
        pay_d[g]  = next_pay;
      end
    end
  end

  // Cell storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.pop) begin
      for (int i = 0; i < CAPACITY; i++) begin
        prio_q[i] <= prio_d[i];
        pay_q[i]  <= pay_d[i];
      end
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= STAT_DONE;
    end else begin
      count_q <= count_d;
      if (cmd_i.err_empty) begin
        status_q <= STAT_EMPTY;
      end else if (cmd_i.err_full) begin
        status_q <= STAT_FULL;
      end else if (cmd_i.push || cmd_i.pop) begin
        status_q <= STAT_DONE;
      end
    end
  end

  // Result beat fields; only a dequeue returns an entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      res_pay_q  <= pay_q[0];
      res_prio_q <= prio_q[0];
    end else if (cmd_i.push || cmd_i.err_empty || cmd_i.err_full) begin
      res_pay_q  <= '0;
      res_prio_q <= '0;
    end
  end

  assign status_o      = status_q;
  assign out_payload_o = res_pay_q;
  assign out_prio_o    = PRIO_W'(res_prio_q);
  assign occupancy_o   = OCC_W'(count_q);

  `SPQ_ASSERT(a_push_grows, cmd_i.push |=> count_q == $past(count_q) + CNT_W'(1))
  `SPQ_ASSERT(a_pop_shrinks, cmd_i.pop |=> count_q == $past(count_q) - CNT_W'(1))
  `SPQ_ASSERT(a_count_holds, !(cmd_i.push || cmd_i.pop) |=> $stable(count_q))
  `SPQ_ASSERT(a_front_sorted, (count_q >= CNT_W'(2)) |-> (prio_q[0] <= prio_q[1]))
  `SPQ_ASSERT(a_count_bounded, count_q <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue top level: controller and cell-chain datapath.
//
// Bounded priority queue of spq_pkg::CAPACITY entries kept in ascending
// order of priority number, equal priorities leaving in arrival order.
// A request beat is taken at a rising edge with start high and busy low.
// Each request takes two cycles: one in which every cell compares its
// priority with the new entry in parallel and the chain shifts, and one in
// which the result beat is shown on the result ports with done_o high for
// exactly that cycle. A new request may be taken in the result cycle, so
// requests follow every two cycles. The receiver cannot stall: the result
// must be taken in the cycle that done_o is high. A full-queue enqueue is
// dropped and reported in status_o.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 req_type_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]           prio_i,
  input  wire logic signed [spq_pkg::PAYLOAD_W-1:0] payload_i,
  output logic                                      done_o,
  output logic [spq_pkg::STATUS_W-1:0]              status_o,
  output logic signed [spq_pkg::PAYLOAD_W-1:0]      out_payload_o,
  output logic [spq_pkg::PRIO_W-1:0]                out_prio_o,
  output logic [spq_pkg::OCC_W-1:0]                 occupancy_o
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  // Sequencing of each request.
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .done_o     (done_o)
  );

  // Entry cells, count and result registers.
  spq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .prio_i        (prio_i),
    .payload_i     (payload_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .out_payload_o (out_payload_o),
    .out_prio_o    (out_prio_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

`default_nettype wire
